### design/ppm_ascii_pixel_parser_core_macros.svh
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser assertion macros
// Concurrent checks that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef PPM_ASCII_PIXEL_PARSER_CORE_MACROS_SVH
`define PPM_ASCII_PIXEL_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PPA_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Expression must never be true outside reset.
`define PPA_ASSERT_NEVER(lbl, ck, rn, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);

`else

`define PPA_ASSERT(lbl, ck, rn, prop, msg)
`define PPA_ASSERT_NEVER(lbl, ck, rn, expr, msg)

`endif

`endif

### design/ppa_pkg.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser package
// Shared widths, constants, register indexes and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppa_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int MAX_PIXELS = 4194304;
  localparam int LIMIT_W    = 25;

  localparam int RECIP_W     = 24;
  localparam int TOTAL_W     = 23;
  localparam int Q_W         = 16;
  localparam int INDEX_W     = 22;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int SCALE_SHIFT = 8;
  localparam int DEC_BASE    = 10;

  localparam logic [Q_W-1:0]     Q_ONE           = 16'h8000;
  localparam logic [RECIP_W-1:0] SCALE_RECIP_RST = 24'd32896;
  localparam logic [TOTAL_W-1:0] PIXEL_TOTAL_RST = 23'd4194304;
  localparam logic [TOTAL_W-1:0] COUNTER_MAX     = '1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_RECIP = 2'd0,
    REG_PIXEL_TOTAL = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // One queued event from the character front end
  typedef struct packed {
    logic has_sample;
    logic set_err;
    logic eos;
  } ppa_evt_t;

  localparam int EVT_W = $bits(ppa_evt_t);

endpackage

### design/ppm_ascii_pixel_parser_core.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser core
// Parses the pixel body of a P3 image into scaled RGB pixels with indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one character (or an end-of-stream marker) per clock and sustains one
// character per cycle as long as results are taken. A front end classifies
// each character and accumulates decimal samples; completed samples, errors
// and end of stream go through a QUEUE_DEPTH-entry event queue to a back end
// with one 16x24 multiplier stage and a result register, which a result reaches
// from the queue via the multiplier register; the queue absorbs result
// backpressure so input keeps flowing until it fills. Registers are written
// through the cfg port (always ready) and must be changed only while idle.
module ppm_ascii_pixel_parser_core #(
  parameter int SAMPLE_BITS = ppa_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = ppa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_char_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppa_pkg::Q_W-1:0]        out_red,
  output logic [ppa_pkg::Q_W-1:0]        out_green,
  output logic [ppa_pkg::Q_W-1:0]        out_blue,
  output logic [ppa_pkg::INDEX_W-1:0]    out_pixel_index,
  output logic                           out_pixel_valid,
  output logic                           out_error_flag,
  output logic                           out_done_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ppa_pkg::*;

  localparam int QDATA_W = EVT_W + SAMPLE_BITS;

  logic [RECIP_W-1:0]     scale_recip_r;
  logic [TOTAL_W-1:0]     pixel_total_r;

  logic                   f_push;
  ppa_evt_t               f_evt;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic                   q_full;
  logic                   q_not_empty;
  logic                   q_pop;
  logic [QDATA_W-1:0]     q_rdata;
  ppa_evt_t               b_evt;
  logic [SAMPLE_BITS-1:0] b_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_recip_r <= SCALE_RECIP_RST;
      pixel_total_r <= PIXEL_TOTAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SCALE_RECIP) begin
        scale_recip_r <= cfg_wdata[RECIP_W-1:0];
      end
      if (cfg_index == REG_PIXEL_TOTAL) begin
        pixel_total_r <= cfg_wdata[TOTAL_W-1:0];
      end
    end
  end

  ppa_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .q_push       (f_push),
    .q_evt        (f_evt),
    .q_sample     (f_sample)
  );

  ppa_fifo #(
    .DATA_W (QDATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_evt, f_sample}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_not_empty)
  );

  assign b_evt    = q_rdata[QDATA_W-1:SAMPLE_BITS];
  assign b_sample = q_rdata[SAMPLE_BITS-1:0];

  ppa_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_evt           (b_evt),
    .q_sample        (b_sample),
    .q_pop           (q_pop),
    .scale_recip     (scale_recip_r),
    .pixel_total     (pixel_total_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_pixel_index (out_pixel_index),
    .out_pixel_valid (out_pixel_valid),
    .out_error_flag  (out_error_flag),
    .out_done_res    (out_done_res)
  );

endmodule

### design/ppa_fifo.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser event queue
// Small register FIFO between the character front end and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppm_ascii_pixel_parser_core_macros.svh"

module ppa_fifo #(
  parameter int DATA_W = 19,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PPA_ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full, "event pushed into full queue")
  `PPA_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !not_empty, "event popped from empty queue")

endmodule

### design/ppa_front.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser front end
// Classifies characters, tracks comments and accumulates decimal samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppa_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_kind,
  input  logic [7:0]             in_char_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output ppa_pkg::ppa_evt_t      q_evt,
  output logic [SAMPLE_BITS-1:0] q_sample
);

  import ppa_pkg::*;

  localparam int WIDE_W = SAMPLE_BITS + 4;
  localparam logic [WIDE_W-1:0] ACCUM_MAX = WIDE_W'((1 << SAMPLE_BITS) - 1);

  logic                   in_number_r, in_number_nxt;
  logic                   in_comment_r, in_comment_nxt;
  logic [SAMPLE_BITS-1:0] accum_r, accum_nxt;
  logic                   accept;
  logic                   is_digit, is_space, is_hash;
  logic [WIDE_W-1:0]      accum_sum;
  ppa_evt_t               evt;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_char_byte >= CHAR_ZERO) && (in_char_byte <= CHAR_NINE);
  assign is_space = (in_char_byte == CHAR_SPACE) ||
                    ((in_char_byte >= CHAR_TAB) && (in_char_byte <= CHAR_CR));
  assign is_hash  = (in_char_byte == CHAR_HASH);

  // Low nibble of an ASCII digit is its value
  assign accum_sum = WIDE_W'(accum_r) * WIDE_W'(DEC_BASE) + WIDE_W'(in_char_byte[3:0]);

  always_comb begin
    in_number_nxt  = in_number_r;
    in_comment_nxt = in_comment_r;
    accum_nxt      = accum_r;
    evt            = '0;
    q_push         = 1'b0;
    if (accept) begin
      priority if (in_kind == KIND_EOS) begin
        evt.eos        = 1'b1;
        evt.has_sample = in_number_r;
        q_push         = 1'b1;
        in_number_nxt  = 1'b0;
        in_comment_nxt = 1'b0;
        accum_nxt      = '0;
      end else if (in_comment_r) begin
        if (in_char_byte == CHAR_LF) begin
          in_comment_nxt = 1'b0;
        end
      end else if (is_digit) begin
        accum_nxt     = (accum_sum > ACCUM_MAX) ? ACCUM_MAX[SAMPLE_BITS-1:0]
                                                : accum_sum[SAMPLE_BITS-1:0];
        in_number_nxt = 1'b1;
      end else begin
        // Any non-digit closes the pending sample
        evt.has_sample = in_number_r;
        evt.set_err    = !is_hash && !is_space;
        q_push         = in_number_r || evt.set_err;
        in_number_nxt  = 1'b0;
        accum_nxt      = '0;
        if (is_hash) begin
          in_comment_nxt = 1'b1;
        end
      end
    end
  end

  assign q_evt    = evt;
  assign q_sample = accum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r  <= 1'b0;
      in_comment_r <= 1'b0;
      accum_r      <= '0;
    end else begin
      in_number_r  <= in_number_nxt;
      in_comment_r <= in_comment_nxt;
      accum_r      <= accum_nxt;
    end
  end

endmodule

### design/ppa_back.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser back end
// Scales samples, assembles pixels, counts them and drives the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppm_ascii_pixel_parser_core_macros.svh"

module ppa_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ppa_pkg::ppa_evt_t             q_evt,
  input  logic [SAMPLE_BITS-1:0]        q_sample,
  output logic                          q_pop,
  input  logic [ppa_pkg::RECIP_W-1:0]   scale_recip,
  input  logic [ppa_pkg::TOTAL_W-1:0]   pixel_total,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppa_pkg::Q_W-1:0]       out_red,
  output logic [ppa_pkg::Q_W-1:0]       out_green,
  output logic [ppa_pkg::Q_W-1:0]       out_blue,
  output logic [ppa_pkg::INDEX_W-1:0]   out_pixel_index,
  output logic                          out_pixel_valid,
  output logic                          out_error_flag,
  output logic                          out_done_res
);

  import ppa_pkg::*;

  localparam int PROD_W   = SAMPLE_BITS + RECIP_W;
  localparam int SCALED_W = PROD_W - SCALE_SHIFT;

  // Multiply stage
  logic              mul_valid_r;
  ppa_evt_t          mul_evt_r;
  logic [PROD_W-1:0] mul_prod_r;
  logic              mul_adv;
  logic              mul_makes_res;

  logic [SCALED_W-1:0] scaled;
  logic [Q_W-1:0]      q_val;

  // Pixel assembly state
  chan_t             chan_r, chan_nxt;
  logic [Q_W-1:0]    red_r, red_nxt;
  logic [Q_W-1:0]    green_r, green_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic              sticky_r, sticky_nxt;
  logic              is_blue;
  logic              in_range;
  logic              err_now;

  // Result fields
  logic [Q_W-1:0]     res_red, res_green, res_blue;
  logic [INDEX_W-1:0] res_index;
  logic               res_pixel_valid;

  // Output register
  logic               out_valid_r;
  logic [Q_W-1:0]     out_red_r, out_green_r, out_blue_r;
  logic [INDEX_W-1:0] out_pixel_index_r;
  logic               out_pixel_valid_r;
  logic               out_error_flag_r;
  logic               out_done_res_r;

  assign scaled = mul_prod_r[PROD_W-1:SCALE_SHIFT];
  assign q_val  = (scaled > SCALED_W'(Q_ONE)) ? Q_ONE : scaled[Q_W-1:0];

  always_comb begin
    unique case (chan_r)
      CH_RED:   is_blue = 1'b0;
      CH_GREEN: is_blue = 1'b0;
      default:  is_blue = mul_evt_r.has_sample;
    endcase
  end

  assign in_range = (cnt_r < pixel_total) &&
                    (LIMIT_W'(cnt_r) < LIMIT_W'(MAX_PIXELS));
  assign err_now  = sticky_r || (is_blue && !in_range) || mul_evt_r.set_err;

  assign mul_makes_res = mul_evt_r.eos || is_blue;
  assign mul_adv       = mul_valid_r && (!mul_makes_res || !out_valid_r || out_ready);
  assign q_pop         = q_valid && (!mul_valid_r || mul_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (q_pop) begin
      mul_valid_r <= 1'b1;
    end else if (mul_adv) begin
      mul_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mul_evt_r  <= q_evt;
      mul_prod_r <= PROD_W'(q_sample) * PROD_W'(scale_recip);
    end
  end

  // Next state of the pixel assembly
  always_comb begin
    chan_nxt   = chan_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    cnt_nxt    = cnt_r;
    sticky_nxt = sticky_r;
    if (mul_adv) begin
      if (mul_evt_r.eos) begin
        chan_nxt   = CH_RED;
        cnt_nxt    = '0;
        sticky_nxt = 1'b0;
      end else begin
        sticky_nxt = err_now;
        if (mul_evt_r.has_sample) begin
          unique case (chan_r)
            CH_RED: begin
              red_nxt  = q_val;
              chan_nxt = CH_GREEN;
            end
            CH_GREEN: begin
              green_nxt = q_val;
              chan_nxt  = CH_BLUE;
            end
            default: begin
              chan_nxt = CH_RED;
              cnt_nxt  = (cnt_r == COUNTER_MAX) ? cnt_r : cnt_r + 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Result fields
  always_comb begin
    res_pixel_valid = is_blue && in_range;
    res_red         = res_pixel_valid ? red_r : '0;
    res_green       = res_pixel_valid ? green_r : '0;
    res_blue        = res_pixel_valid ? q_val : '0;
    res_index       = res_pixel_valid ? cnt_r[INDEX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r   <= CH_RED;
      cnt_r    <= '0;
      sticky_r <= 1'b0;
    end else begin
      chan_r   <= chan_nxt;
      cnt_r    <= cnt_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // Red and green are always written before a pixel reads them
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mul_adv && mul_makes_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_adv && mul_makes_res) begin
      out_red_r         <= res_red;
      out_green_r       <= res_green;
      out_blue_r        <= res_blue;
      out_pixel_index_r <= res_index;
      out_pixel_valid_r <= res_pixel_valid;
      out_error_flag_r  <= err_now;
      out_done_res_r    <= mul_evt_r.eos;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_pixel_valid = out_pixel_valid_r;
  assign out_error_flag  = out_error_flag_r;
  assign out_done_res    = out_done_res_r;

  `PPA_ASSERT(a_res_has_cause, clk, rst_n, out_valid_r && !out_done_res_r |-> out_pixel_valid_r || out_error_flag_r, "mid-stream beat without pixel or error")
  `PPA_ASSERT(a_q_clamped, clk, rst_n, out_valid_r && out_pixel_valid_r |-> out_red_r <= Q_ONE && out_green_r <= Q_ONE && out_blue_r <= Q_ONE, "color above 1.0")
  `PPA_ASSERT(a_eos_clears, clk, rst_n, mul_adv && mul_evt_r.eos |=> cnt_r == '0 && !sticky_r && chan_r == CH_RED, "end of stream left state behind")

endmodule

### verif/ppa_pixel_checker.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser checker
// Watches the character, result and register channels. Keeps its own model
// of the parser, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppa_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_char_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ppa_pkg::Q_W-1:0]        out_red,
  input  logic [ppa_pkg::Q_W-1:0]        out_green,
  input  logic [ppa_pkg::Q_W-1:0]        out_blue,
  input  logic [ppa_pkg::INDEX_W-1:0]    out_pixel_index,
  input  logic                           out_pixel_valid,
  input  logic                           out_error_flag,
  input  logic                           out_done_res,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             waiting,
  output int                             chars_seen,
  output int                             eos_seen,
  output int                             results_seen,
  output int                             pixels_ok
);
  import ppa_pkg::*;

  localparam int ACC_MAX = (1 << SAMPLE_BITS_DEF) - 1;

  typedef struct packed {
    logic [Q_W-1:0]     red;
    logic [Q_W-1:0]     green;
    logic [Q_W-1:0]     blue;
    logic [INDEX_W-1:0] index;
    logic               pix_ok;
    logic               err;
    logic               done;
  } pixel_beat_t;

  pixel_beat_t pending_pixels[$];

  // register shadows
  logic [RECIP_W-1:0] recip;
  logic [TOTAL_W-1:0] total;

  // parser state
  logic               num_active;
  logic               skip_comment;
  logic [Q_W-1:0]     accum;
  chan_t              chan;
  logic [Q_W-1:0]     red_q;
  logic [Q_W-1:0]     green_q;
  logic [TOTAL_W-1:0] pix_count;
  logic               err_sticky;

  int fails = 0;
  int char_count = 0;
  int eos_count = 0;
  int result_count = 0;
  int pixel_count = 0;

  assign mismatches   = fails;
  assign chars_seen   = char_count;
  assign eos_seen     = eos_count;
  assign results_seen = result_count;
  assign pixels_ok    = pixel_count;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [Q_W-1:0] scale_sample(input logic [Q_W-1:0] s);
    logic [63:0] p;
    p = ({48'd0, s} * {40'd0, recip}) >> SCALE_SHIFT;
    if (p > {48'd0, Q_ONE}) return Q_ONE;
    return p[Q_W-1:0];
  endfunction

  task automatic clear_parser();
    num_active   = 1'b0;
    skip_comment = 1'b0;
    accum        = '0;
    chan         = CH_RED;
    red_q        = '0;
    green_q      = '0;
    pix_count    = '0;
    err_sticky   = 1'b0;
  endtask

  // Finish the pending sample; a blue one yields a result beat.
  task automatic close_sample(output logic emitted, output pixel_beat_t r);
    logic [Q_W-1:0] q;
    r = '0;
    emitted = 1'b0;
    if (!num_active) return;
    q = scale_sample(accum);
    num_active = 1'b0;
    accum = '0;
    case (chan)
      CH_RED: begin
        red_q = q;
        chan = CH_GREEN;
      end
      CH_GREEN: begin
        green_q = q;
        chan = CH_BLUE;
      end
      default: begin
        chan = CH_RED;
        if (pix_count < total && pix_count < MAX_PIXELS) begin
          r.red    = red_q;
          r.green  = green_q;
          r.blue   = q;
          r.index  = pix_count[INDEX_W-1:0];
          r.pix_ok = 1'b1;
        end else begin
          err_sticky = 1'b1;
        end
        if (pix_count != COUNTER_MAX) pix_count = pix_count + 1'b1;
        r.err = err_sticky;
        emitted = 1'b1;
      end
    endcase
  endtask

  task automatic parse_beat(input logic kind, input logic [7:0] c);
    logic        hit;
    pixel_beat_t r;
    logic [31:0] v;
    if (kind == KIND_EOS) begin
      eos_count++;
      close_sample(hit, r);
      r.err  = err_sticky;
      r.done = 1'b1;
      pending_pixels.push_back(r);
      clear_parser();
    end else begin
      char_count++;
      if (skip_comment) begin
        if (c == CHAR_LF) skip_comment = 1'b0;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        v = 32'(accum) * 32'(DEC_BASE) + 32'(c) - 32'(CHAR_ZERO);
        accum = (v > ACC_MAX) ? Q_W'(ACC_MAX) : v[Q_W-1:0];
        num_active = 1'b1;
      end else begin
        close_sample(hit, r);
        if (c == CHAR_HASH) begin
          skip_comment = 1'b1;
        end else if (!is_blank(c)) begin
          err_sticky = 1'b1;
          r.err = 1'b1;
        end
        if (hit) pending_pixels.push_back(r);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    pixel_beat_t want;
    result_count++;
    if (out_pixel_valid) pixel_count++;
    if (pending_pixels.size() == 0) begin
      fails++;
      $display("%0t ns: result beat with nothing expected, expected none, actual index %0d",
               $time, out_pixel_index);
    end else begin
      want = pending_pixels.pop_front();
      compare_field("red", 32'(want.red), 32'(out_red));
      compare_field("green", 32'(want.green), 32'(out_green));
      compare_field("blue", 32'(want.blue), 32'(out_blue));
      compare_field("pixel_index", 32'(want.index), 32'(out_pixel_index));
      compare_field("pixel_valid", 32'(want.pix_ok), 32'(out_pixel_valid));
      compare_field("error_flag", 32'(want.err), 32'(out_error_flag));
      compare_field("done_res", 32'(want.done), 32'(out_done_res));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      recip = SCALE_RECIP_RST;
      total = PIXEL_TOTAL_RST;
      clear_parser();
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCALE_RECIP: recip = cfg_wdata[RECIP_W-1:0];
          REG_PIXEL_TOTAL: total = cfg_wdata[TOTAL_W-1:0];
          default: ;
        endcase
      end
      // results lag their characters, so check before predicting this edge
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_beat(in_kind, in_char_byte);
    end
    waiting <= pending_pixels.size();
  end

endmodule

### verif/ppm_ascii_pixel_parser_core_tb.sv
// ----------------------------------------------------------------------------
// PPM ASCII pixel parser core testbench
// Streams directed and random P3 pixel text (samples, blanks, comments, bad
// characters, end-of-stream marks) under several register settings and
// handshake stall mixes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppm_ascii_pixel_parser_core_tb;
  import ppa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_kind;
  logic [7:0]            in_char_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [Q_W-1:0]        out_red;
  logic [Q_W-1:0]        out_green;
  logic [Q_W-1:0]        out_blue;
  logic [INDEX_W-1:0]    out_pixel_index;
  logic                  out_pixel_valid;
  logic                  out_error_flag;
  logic                  out_done_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int waiting;
  int chars_seen;
  int eos_seen;
  int results_seen;
  int pixels_ok;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int images_sent   = 0;
  int cycle_count   = 0;

  ppm_ascii_pixel_parser_core dut (.*);

  ppa_pixel_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run exceeded %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, waiting);
      $display("ppm_ascii_pixel_parser_core_tb: FAIL");
      $finish;
    end
  end

  // Hold the beat until accepted; ready is sampled mid-cycle.
  task automatic push_item(input logic kind, input logic [7:0] ch);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_char_byte <= ch;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(KIND_CHAR, s[i]);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] blank_byte();
    int pick;
    pick = $urandom_range(5);
    if (pick == 5) return CHAR_SPACE;
    return CHAR_TAB + 8'(pick);
  endfunction

  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_HASH || b == CHAR_SPACE ||
           (b >= CHAR_TAB && b <= CHAR_CR));
    return b;
  endfunction

  task automatic send_sample();
    int unsigned val;
    int          pick;
    string       s;
    pick = $urandom_range(99);
    if (pick < 65) val = $urandom_range(255);
    else if (pick < 85) val = $urandom_range(65535);
    else val = $urandom_range(999999);
    s = $sformatf("%0d", val);
    if ($urandom_range(9) == 0) s = {"00", s};
    send_text(s);
  endtask

  task automatic send_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      push_item(KIND_CHAR, CHAR_HASH);
      repeat ($urandom_range(6)) begin
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CHAR_LF);
        push_item(KIND_CHAR, b);
      end
      push_item(KIND_CHAR, CHAR_LF);
    end else if (pick < 12) begin
      push_item(KIND_CHAR, odd_byte());
    end else begin
      repeat ($urandom_range(1, 2)) push_item(KIND_CHAR, blank_byte());
    end
  endtask

  // One stream: mostly well-formed pixel text, sometimes raw noise.
  task automatic send_image();
    int n_samples;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 20)) push_item(KIND_CHAR, 8'($urandom_range(255)));
    end else begin
      n_samples = $urandom_range(36);
      for (int k = 0; k < n_samples; k++) begin
        send_sample();
        if (k != n_samples - 1 || $urandom_range(1) == 1) send_gap();
      end
    end
    push_item(KIND_EOS, 8'($urandom_range(255)));
    images_sent++;
  endtask

  task automatic apply_setting(input int sel);
    logic [CFG_DATA_W-1:0] r;
    logic [CFG_DATA_W-1:0] t;
    case (sel % 6)
      0: begin r = 24'h800000; t = 24'd0; end
      1: begin r = 24'd0; t = 24'd4194304; end
      2: begin r = 24'd128; t = 24'd3; end
      3: begin r = 24'($urandom_range(8388608)); t = 24'($urandom_range(12)); end
      4: begin r = SCALE_RECIP_RST; t = 24'(PIXEL_TOTAL_RST); end
      default: begin r = 24'($urandom_range(65535)); t = 24'($urandom_range(1, 4194304)); end
    endcase
    write_reg(REG_SCALE_RECIP, r);
    write_reg(REG_PIXEL_TOTAL, t);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_CHAR;
    in_char_byte = 8'h00;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SCALE_RECIP;
    cfg_wdata    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, full scale, saturation, comment with bad bytes,
    // bad character ending a sample, pending pixel closed by end of stream
    send_text("0 255\t99999#");
    push_item(KIND_CHAR, 8'hFF);
    send_text("A\n1\r2!3");
    push_item(KIND_EOS, 8'hA5);
    push_item(KIND_EOS, 8'h00);
    push_item(KIND_CHAR, CHAR_HASH);
    push_item(KIND_EOS, 8'hFF);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 19; recv_idle_pct <= 75; end
        1: begin send_idle_pct = 75; recv_idle_pct <= 19; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      while (items_sent < 25 + (phase + 1) * (ITEM_TARGET - 25) / 3) begin
        apply_setting(images_sent);
        send_image();
        wait_drained();
      end
    end

    $display("Sent %0d characters over %0d streams, each closed by an end-of-stream mark.",
             chars_seen, eos_seen);
    $display("Checked %0d result beats, %0d in-range pixels, over 6 register mixes.",
             results_seen, pixels_ok);
    if (mismatches == 0) begin
      $display("ppm_ascii_pixel_parser_core_tb: PASS");
    end else begin
      $display("ppm_ascii_pixel_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ppa_pkg.sv
design/ppa_fifo.sv
design/ppa_front.sv
design/ppa_back.sv
design/ppm_ascii_pixel_parser_core.sv
verif/ppa_pixel_checker.sv
verif/ppm_ascii_pixel_parser_core_tb.sv
